>>> rtl/bsum_pkg.sv
// Package for the 3x3 box-sum stream block.
// Holds the register map and the fixed sizes of the configuration port.
// Depends on nothing; the top level and the testbench import it.
`default_nettype none

package bsum_pkg;

   // Configuration port: two registers at byte addresses 0 and 4.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from bit 2 of the byte address.
   typedef enum logic {
      CSR_FRAME_COLS = 1'b0,
      CSR_FRAME_ROWS = 1'b1
   } csr_index_type;

   // Frame size after reset, both for columns and for rows.
   localparam int FRAME_SIZE_RESET = 1024;

   // Smallest frame size that the counters accept.
   localparam int FRAME_SIZE_MIN = 3;

endpackage

`default_nettype wire

>>> rtl/bsum_req_if.sv
// Input channel of the 3x3 box-sum stream: one grid cell per transfer.
// Valid/ready handshake; depends on nothing else.
`default_nettype none

interface bsum_req_if #(
   parameter int VALUE_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

>>> rtl/bsum_rsp_if.sv
// Result channel of the 3x3 box-sum stream: one window sum per transfer.
// Valid/ready handshake; depends on nothing else.
`default_nettype none

interface bsum_rsp_if #(
   parameter int SUM_W = 12,
   parameter int ROW_W = 12,
   parameter int COL_W = 10
);
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] window_sum;
   logic [ROW_W-1:0] centre_row;
   logic [COL_W-1:0] centre_col;
   logic             frame_last;

   modport source (output valid, output window_sum, output centre_row,
                   output centre_col, output frame_last, input ready);
   modport sink   (input valid, input window_sum, input centre_row,
                   input centre_col, input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/box_sum_3x3_stream.sv
// Top level of the 3x3 box-sum stream: line memory, column sums, counters, CSRs.
// Depends on bsum_pkg and on the interfaces bsum_req_if and bsum_rsp_if.
// A cell's transfer reads the line memory and loads stage 1; stage 1 forms the window
// sum and registers it into the output register, which offers it on rsp.
// Throughput: one cell per cycle unless a full output register stalls stage 1, set by
// the single read and single write port of the line memory, both used once per cell.
// Reset clears the counters, column sums, pipeline valids and the frame size
// registers (1024 x 1024); the line memory is not cleared and needs no sweep.
`default_nettype none

module box_sum_3x3_stream #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 4096,
   parameter int VALUE_BITS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bsum_req_if.sink                              req_if,
   bsum_rsp_if.source                            rsp_if,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bsum_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [bsum_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [bsum_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);
   import bsum_pkg::*;

   // Column and row counters index the line memory and the frame directly.
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   // The size registers must hold the largest size itself.
   localparam int CCFG_W = $clog2(MAX_COLS + 1);
   localparam int RCFG_W = $clog2(MAX_ROWS + 1);
   // Three cells make a column sum, three column sums make the window sum.
   localparam int CS_W   = VALUE_BITS + 2;
   localparam int SUM_W  = VALUE_BITS + 4;

   localparam logic [CCFG_W-1:0] COLS_RESET =
      CCFG_W'((MAX_COLS < FRAME_SIZE_RESET) ? MAX_COLS : FRAME_SIZE_RESET);
   localparam logic [RCFG_W-1:0] ROWS_RESET =
      RCFG_W'((MAX_ROWS < FRAME_SIZE_RESET) ? MAX_ROWS : FRAME_SIZE_RESET);

   // ------------------------------------------------------------------------
   // Configuration registers. pready is tied high, so every write completes
   // in its access phase. Bit 2 of the byte address selects the register and
   // the low address bits are not decoded.
   // ------------------------------------------------------------------------
   logic [CCFG_W-1:0] frame_cols_ff, frame_cols_in;
   logic [RCFG_W-1:0] frame_rows_ff, frame_rows_in;
   logic              csr_write;
   csr_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frame_cols_in = frame_cols_ff;
      frame_rows_in = frame_rows_ff;
      csr_prdata    = '0;
      unique case (csr_index)
         CSR_FRAME_COLS: begin
            csr_prdata = CSR_DATA_W'(frame_cols_ff);
            if (csr_write) begin
               frame_cols_in = csr_pwdata[CCFG_W-1:0];
            end
         end
         CSR_FRAME_ROWS: begin
            csr_prdata = CSR_DATA_W'(frame_rows_ff);
            if (csr_write) begin
               frame_rows_in = csr_pwdata[RCFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cols_ff <= COLS_RESET;
         frame_rows_ff <= ROWS_RESET;
      end else begin
         frame_cols_ff <= frame_cols_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   // The programmed sizes are clamped to the range the counters support.
   logic [CCFG_W-1:0] cols_eff;
   logic [RCFG_W-1:0] rows_eff;

   always_comb begin
      if (frame_cols_ff < CCFG_W'(FRAME_SIZE_MIN)) begin
         cols_eff = CCFG_W'(FRAME_SIZE_MIN);
      end else if (frame_cols_ff > CCFG_W'(MAX_COLS)) begin
         cols_eff = CCFG_W'(MAX_COLS);
      end else begin
         cols_eff = frame_cols_ff;
      end
      if (frame_rows_ff < RCFG_W'(FRAME_SIZE_MIN)) begin
         rows_eff = RCFG_W'(FRAME_SIZE_MIN);
      end else if (frame_rows_ff > RCFG_W'(MAX_ROWS)) begin
         rows_eff = RCFG_W'(MAX_ROWS);
      end else begin
         rows_eff = frame_rows_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 0: a cell transfer. The counters give the cell's position; the
   // line memory is read at its column, and the position, the cell value and
   // the window flags move into stage 1.
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_wrap, row_wrap;
   logic             req_fire;
   logic             s1_ready;

   assign col_wrap = (CCFG_W'(col_ff) + CCFG_W'(1)) >= cols_eff;
   assign row_wrap = (RCFG_W'(row_ff) + RCFG_W'(1)) >= rows_eff;

   assign req_if.ready = s1_ready;
   assign req_fire     = req_if.valid && s1_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line memory: each entry holds the cell two rows up (upper half) and the
   // cell one row up (lower half) of one column. One read and one write per
   // cell. The read of a cell and the write-back of the cell before it always
   // fall on different columns, since a row is at least three cells long, and
   // every earlier cell has already been written back by then, so no
   // forwarding is needed.
   logic [2*VALUE_BITS-1:0] line_mem [MAX_COLS];
   logic [2*VALUE_BITS-1:0] line_rd_ff;
   logic [2*VALUE_BITS-1:0] line_wr_data;
   logic                    s1_adv;

   // Stage 1 registers.
   logic                  s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0] s1_value_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (s1_adv) begin
         line_mem[s1_col_ff] <= line_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_value_ff <= req_if.cell_value;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         // Only a cell at row two or beyond and column two or beyond closes
         // a full window; the border cells give no result.
         s1_emit_ff  <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff  <= row_wrap && col_wrap;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: form the new column sum and the window sum, write the column
   // back shifted down by one row, and hand any result to the output register.
   // The stage moves on unless it holds a result and the output register is
   // full and not being emptied; the input is refused only in that case.
   // ------------------------------------------------------------------------
   logic [VALUE_BITS-1:0] cell_upper, cell_middle;
   logic [CS_W-1:0]       colsum_new;
   logic [SUM_W-1:0]      window_sum_new;
   logic [CS_W-1:0]       colsum_left_ff, colsum_left_in;
   logic [CS_W-1:0]       colsum_mid_ff, colsum_mid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]      rsp_sum_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic [COL_W-1:0]      rsp_col_ff;
   logic                  rsp_last_ff;

   assign cell_upper  = line_rd_ff[2*VALUE_BITS-1:VALUE_BITS];
   assign cell_middle = line_rd_ff[VALUE_BITS-1:0];

   assign colsum_new     = CS_W'(cell_upper) + CS_W'(cell_middle) + CS_W'(s1_value_ff);
   assign window_sum_new = SUM_W'(colsum_left_ff) + SUM_W'(colsum_mid_ff)
                         + SUM_W'(colsum_new);
   assign line_wr_data   = {cell_middle, s1_value_ff};

   assign s1_adv   = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_if.ready);
   assign s1_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      colsum_left_in = colsum_left_ff;
      colsum_mid_in  = colsum_mid_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in    = 1'b0;
         colsum_left_in = colsum_mid_ff;
         colsum_mid_in  = colsum_new;
         if (s1_emit_ff) begin
            rsp_valid_in = 1'b1;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         colsum_left_ff <= '0;
         colsum_mid_ff  <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         colsum_left_ff <= colsum_left_in;
         colsum_mid_ff  <= colsum_mid_in;
      end
   end

   // The output register holds a result until its transfer; the window centre
   // lies one row up and one column left of the cell that closed the window.
   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_sum_ff  <= window_sum_new;
         rsp_row_ff  <= s1_row_ff - ROW_W'(1);
         rsp_col_ff  <= s1_col_ff - COL_W'(1);
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.window_sum = rsp_sum_ff;
   assign rsp_if.centre_row = rsp_row_ff;
   assign rsp_if.centre_col = rsp_col_ff;
   assign rsp_if.frame_last = rsp_last_ff;

endmodule

`default_nettype wire

>>> verif/tb_box_sum_3x3_stream.sv
// Self-checking testbench for the 3x3 box-sum stream block.
// A scoreboard class keeps its own line stores and counters and predicts every window sum.
// Depends on bsum_pkg, bsum_req_if, bsum_rsp_if and box_sum_3x3_stream.

module tb_box_sum_3x3_stream;

   import bsum_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_COLS      = 1024;
   localparam int MAX_ROWS      = 4096;
   localparam int VALUE_BITS    = 8;
   localparam int COLS_REG_W    = 11;
   localparam int ROWS_REG_W    = 13;
   localparam int MAX_GAP       = 19;
   localparam int LONG_HOLD_OFF = 200;
   // Clock edges waited after the last expected result, so that the pipeline runs dry.
   localparam int DRAIN_CYCLES  = 4;
   localparam int LIMIT_CYCLES  = 1000000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SPARSE,
      IDLE_FULL
   } idle_mode_type;

   // Field order matches the concatenation used when a result transfer is sampled.
   typedef struct packed {
      logic [11:0] window_sum;
      logic [11:0] centre_row;
      logic [9:0]  centre_col;
      logic        frame_last;
   } window_result_type;

   // Scoreboard: mirrors the frame registers, the two line stores, the two column sums
   // and the position counters, and holds the window sums still owed by the block.
   class window_sum_tracker;
      logic [COLS_REG_W-1:0] cols_word;
      logic [ROWS_REG_W-1:0] rows_word;
      logic [VALUE_BITS-1:0] upper_line [];
      logic [VALUE_BITS-1:0] middle_line [];
      logic [9:0]            left_colsum;
      logic [9:0]            mid_colsum;
      logic [11:0]           row_pos;
      logic [9:0]            col_pos;
      window_result_type     pending_windows [$];
      int                    failures;

      function new();
         cols_word   = COLS_REG_W'(FRAME_SIZE_RESET);
         rows_word   = ROWS_REG_W'(FRAME_SIZE_RESET);
         upper_line  = new[MAX_COLS];
         middle_line = new[MAX_COLS];
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         left_colsum = '0;
         mid_colsum  = '0;
         row_pos     = '0;
         col_pos     = '0;
         failures    = 0;
      endfunction

      function int clamp_size(int size, int hi);
         if (size < FRAME_SIZE_MIN) begin
            return FRAME_SIZE_MIN;
         end
         if (size > hi) begin
            return hi;
         end
         return size;
      endfunction

      function int active_cols();
         return clamp_size(int'(cols_word), MAX_COLS);
      endfunction

      function int active_rows();
         return clamp_size(int'(rows_word), MAX_ROWS);
      endfunction

      function bit at_frame_start();
         return (row_pos == 0) && (col_pos == 0);
      endfunction

      // Cells still to come before the counters wrap to the top of a frame.
      function int cells_to_frame_end();
         int cols;
         int rows;
         int r;
         int c;
         int row_rest;
         cols = active_cols();
         rows = active_rows();
         r = int'(row_pos);
         c = int'(col_pos);
         row_rest = (c + 1 >= cols) ? 1 : cols - c;
         if (r + 1 >= rows) begin
            return row_rest;
         end
         return (rows - 1 - r) * cols + row_rest;
      endfunction

      function int pending();
         return pending_windows.size();
      endfunction

      // One accepted cell: form its column sum and, if it closes a window, the result.
      function void note_cell(logic [VALUE_BITS-1:0] pixel);
         int                cols;
         int                rows;
         int                r;
         int                c;
         int                colsum;
         window_result_type want;
         cols   = active_cols();
         rows   = active_rows();
         r      = int'(row_pos);
         c      = int'(col_pos);
         colsum = int'(upper_line[c]) + int'(middle_line[c]) + int'(pixel);
         if (r >= 2 && c >= 2) begin
            want.window_sum = 12'(int'(left_colsum) + int'(mid_colsum) + colsum);
            want.centre_row = 12'(r - 1);
            want.centre_col = 10'(c - 1);
            want.frame_last = (r + 1 >= rows) && (c + 1 >= cols);
            pending_windows.insert(pending_windows.size(), want);
         end
         left_colsum    = mid_colsum;
         mid_colsum     = 10'(colsum);
         upper_line[c]  = middle_line[c];
         middle_line[c] = pixel;
         if (c + 1 >= cols) begin
            col_pos = '0;
            row_pos = (r + 1 >= rows) ? 12'd0 : 12'(r + 1);
         end else begin
            col_pos = 10'(c + 1);
         end
      endfunction

      function void check_window(window_result_type got);
         window_result_type want;
         if (pending_windows.size() == 0) begin
            $error("window_sum %0d for row %0d col %0d arrived with nothing expected",
                   got.window_sum, got.centre_row, got.centre_col);
            failures++;
            return;
         end
         want = pending_windows.pop_front();
         if (got.window_sum !== want.window_sum) begin
            $error("window_sum: expected %0d, got %0d", want.window_sum, got.window_sum);
            failures++;
         end
         if (got.centre_row !== want.centre_row) begin
            $error("centre_row: expected %0d, got %0d", want.centre_row, got.centre_row);
            failures++;
         end
         if (got.centre_col !== want.centre_col) begin
            $error("centre_col: expected %0d, got %0d", want.centre_col, got.centre_col);
            failures++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bsum_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   bsum_rsp_if                            rsp_bus ();

   window_sum_tracker tracker;
   idle_mode_type     send_mode;
   idle_mode_type     recv_mode;
   bit                hold_off_due;
   int                csr_faults;

   box_sum_3x3_stream #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .VALUE_BITS (VALUE_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a correct run finishes in a fraction of this time, so reaching it means
   // that a handshake has hung or that expected results never turned up.
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("TB_ERROR");
      $finish;
   end

   // Gap before a transfer. Sparse mode gives long runs of back-to-back transfers with
   // the odd pause; full mode draws uniformly over the whole range.
   function automatic int draw_gap(idle_mode_type mode);
      if (mode == IDLE_NONE) begin
         return 0;
      end
      if (mode == IDLE_FULL) begin
         return $urandom_range(0, MAX_GAP);
      end
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
   endfunction

   // Cell values lean towards the two extremes so that saturated windows turn up often.
   function automatic logic [VALUE_BITS-1:0] draw_cell();
      logic [VALUE_BITS-1:0] pixel;
      case ($urandom_range(0, 9))
         0: begin
            pixel = '0;
         end
         1: begin
            pixel = '1;
         end
         default: begin
            pixel = VALUE_BITS'($urandom);
         end
      endcase
      return pixel;
   endfunction

   // One APB transfer: a setup cycle, then an access cycle that completes on pready.
   // The bus is left idle afterwards so that back-to-back calls never
   // drive psel twice within one time step.
   task automatic csr_access(input logic write, input csr_index_type index,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_frame_reg(input csr_index_type index,
                                  input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, index, '0, readback);
      if (readback !== want) begin
         $error("%s: expected %0d, got %0d", index.name(), want, readback);
         csr_faults++;
      end
   endtask

   // The register holds the raw written value at its own width; any clamping happens
   // only where the size is used, so the read-back shows the unclamped value.
   task automatic write_frame_reg(input csr_index_type index,
                                  input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] stored;
      csr_access(1'b1, index, value, readback);
      if (index == CSR_FRAME_COLS) begin
         tracker.cols_word = value[COLS_REG_W-1:0];
         stored = CSR_DATA_W'(value[COLS_REG_W-1:0]);
      end else begin
         tracker.rows_word = value[ROWS_REG_W-1:0];
         stored = CSR_DATA_W'(value[ROWS_REG_W-1:0]);
      end
      check_frame_reg(index, stored);
   endtask

   // Presents one cell and holds it until the block takes it. Valid stays high between
   // back-to-back cells, so it receives exactly one assignment per time step.
   task automatic offer_cell(input logic [VALUE_BITS-1:0] pixel, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cell_value <= pixel;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_cell(pixel);
   endtask

   task automatic stream_cells(input int count);
      repeat (count) offer_cell(draw_cell(), draw_gap(send_mode));
      req_bus.valid <= 1'b0;
   endtask

   // Waits until every predicted window sum has been received, then lets the pipeline
   // run dry, since trailing border cells leave nothing in the queue to wait for.
   task automatic await_drain();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One phase of the run: new frame size, then a batch of random cells.
   // Narrowing the row or changing the row count mid-frame is always safe, as the line
   // stores already hold every column that will be read. Widening mid-frame would make
   // the block read line-store entries that were never written, so the current frame is
   // first cut short (row count set to the minimum) and streamed to its end.
   task automatic run_phase(input logic [CSR_DATA_W-1:0] cols_value,
                            input logic [CSR_DATA_W-1:0] rows_value,
                            input int cell_count, input bit squeeze);
      int new_cols;
      new_cols  = tracker.clamp_size(int'(cols_value[COLS_REG_W-1:0]), MAX_COLS);
      send_mode = squeeze ? IDLE_NONE : idle_mode_type'($urandom_range(0, 2));
      recv_mode = idle_mode_type'($urandom_range(0, 2));
      if (!tracker.at_frame_start() && new_cols > tracker.active_cols()) begin
         write_frame_reg(CSR_FRAME_ROWS, FRAME_SIZE_MIN);
         stream_cells(tracker.cells_to_frame_end());
         await_drain();
      end
      write_frame_reg(CSR_FRAME_COLS, cols_value);
      write_frame_reg(CSR_FRAME_ROWS, rows_value);
      hold_off_due = squeeze;
      stream_cells(cell_count);
      await_drain();
   endtask

   // Result side: a fresh stall is drawn for every transfer. When a long hold-off has
   // been requested, ready stays low for that many cycles, counted here, while the
   // sender keeps offering cells, so the block fills and back-pressures its input.
   initial begin : result_sink
      int                stall;
      window_result_type seen;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_due) begin
            stall = LONG_HOLD_OFF;
            hold_off_due = 1'b0;
         end else begin
            stall = draw_gap(recv_mode);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         seen = {rsp_bus.window_sum, rsp_bus.centre_row, rsp_bus.centre_col,
                 rsp_bus.frame_last};
         tracker.check_window(seen);
      end
   end

   initial begin : stimulus
      int cols_value;
      int rows_value;
      tracker      = new();
      send_mode    = IDLE_FULL;
      recv_mode    = IDLE_FULL;
      hold_off_due = 1'b0;
      csr_faults   = 0;

      // Every input is driven to a known level before the first clock edge.
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cell_value <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Both frame registers must come out of reset at 1024.
      check_frame_reg(CSR_FRAME_COLS, FRAME_SIZE_RESET);
      check_frame_reg(CSR_FRAME_ROWS, FRAME_SIZE_RESET);

      // Directed part. Sizes below the minimum are clamped to 3 x 3, so each frame of
      // nine cells has only one interior cell, whose window is the whole frame and which
      // carries the end-of-frame flag; the other eight are border cells. An all-ones
      // frame gives the largest possible sum, an all-zeros frame the smallest.
      write_frame_reg(CSR_FRAME_COLS, 0);
      write_frame_reg(CSR_FRAME_ROWS, FRAME_SIZE_MIN - 1);
      repeat (9) offer_cell('1, draw_gap(send_mode));
      repeat (9) offer_cell('0, draw_gap(send_mode));
      req_bus.valid <= 1'b0;
      await_drain();

      // Widest row, written above its range so that it clamps to the maximum, over the
      // shortest frame; only the start of the first row is sent.
      run_phase(2047, 0, 60, 1'b0);

      // Both sizes at their exact maximum; only a partial first row is sent.
      run_phase(MAX_COLS, MAX_ROWS, 40, 1'b0);

      // Narrow the row mid-frame (the column counter is far beyond the new width and
      // must wrap on the next cell), with a row count above range. The receiver holds
      // off for a long stretch while cells keep coming.
      run_phase(FRAME_SIZE_MIN, 8191, 200, 1'b1);

      // Random part: small frames so that windows, row wraps and frame ends come often.
      // Phases start wherever the previous one stopped, so most changes land mid-frame.
      repeat (10) begin
         cols_value = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_SIZE_MIN - 1)
                                                  : $urandom_range(FRAME_SIZE_MIN, 12);
         rows_value = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FRAME_SIZE_MIN - 1)
                                                  : $urandom_range(FRAME_SIZE_MIN, 10);
         run_phase(cols_value, rows_value, $urandom_range(10, 60), 1'b0);
      end

      if (tracker.failures == 0 && csr_faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bsum_pkg.sv
rtl/bsum_req_if.sv
rtl/bsum_rsp_if.sv
rtl/box_sum_3x3_stream.sv
verif/tb_box_sum_3x3_stream.sv
